### rtl/pcg_pkg.sv
// Shared types, constants and codes for the PCG generator with jump-ahead.
`default_nettype none

package pcg_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = WordW / 2;
	localparam int unsigned ReqW = 3;
	localparam int unsigned OffsW = 8;
	localparam int unsigned RotW = 6;
	localparam int unsigned RotSelW = 5;

	typedef logic [WordW-1:0] word_t;
	typedef logic [HalfW-1:0] half_t;
	typedef logic [RotW-1:0] rot_t;

	localparam word_t LCG_MULT = 64'd6364136223846793005;
	localparam word_t LCG_INC = 64'd1442695040888963407;
	localparam word_t LCG_STRIDE = 64'd152917;
	localparam word_t PERM_MULT = 64'd12605985483714917081;
	localparam rot_t PERM_ROT_ADD = 6'd5;
	localparam int unsigned PERM_XS_SHIFT = 43;

	typedef enum logic [ReqW-1:0] {
		REQ_NEXT = 3'd0,
		REQ_SKIP = 3'd1,
		REQ_LOAD = 3'd2,
		REQ_STREAM = 3'd3,
		REQ_PEEK = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		MUL_LL = 2'd0,
		MUL_LH = 2'd1,
		MUL_HL = 2'd2
	} mul_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0,
		ST_STRIDE = 4'd1,
		ST_JTEST = 4'd2,
		ST_JMUL = 4'd3,
		ST_JINC = 4'd4,
		ST_JINC2 = 4'd5,
		ST_JSQR = 4'd6,
		ST_JAPPLY = 4'd7,
		ST_STEP = 4'd8,
		ST_PERM = 4'd9,
		ST_FIN = 4'd10
	} seq_state_t;

	// Operands of one multiply-add: p = a * b + c (mod 2^64).
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
	} mul_op_t;

endpackage

`default_nettype wire

### rtl/pcg_req_if.sv
// Request channel: valid/ready handshake with the request fields.
`default_nettype none

interface pcg_req_if;
	logic valid;
	logic ready;
	logic [pcg_pkg::ReqW-1:0] req_type;
	pcg_pkg::word_t step_count;
	pcg_pkg::word_t seed_in;
	logic [pcg_pkg::OffsW-1:0] stream_offset;

	modport source (output valid, output req_type, output step_count, output seed_in,
		output stream_offset, input ready);
	modport sink (input valid, input req_type, input step_count, input seed_in,
		input stream_offset, output ready);
endinterface

`default_nettype wire

### rtl/pcg_res_if.sv
// Result channel: valid/ready handshake with the result word.
`default_nettype none

interface pcg_res_if;
	logic valid;
	logic ready;
	pcg_pkg::word_t result_value;

	modport source (output valid, output result_value, input ready);
	modport sink (input valid, input result_value, output ready);
endinterface

`default_nettype wire

### rtl/pcg_cfg_if.sv
// Configuration write channel carrying the base seed register.
`default_nettype none

interface pcg_cfg_if;
	logic valid;
	logic ready;
	logic signed [pcg_pkg::WordW-1:0] base_seed;

	modport source (output valid, output base_seed, input ready);
	modport sink (input valid, input base_seed, output ready);
endinterface

`default_nettype wire

### rtl/pcg_rxs_m_xs_with_skip_ahead.sv
// Top level: PCG-RXS-M-XS generator with LCG jump-ahead, sequenced over one multiplier.
//
// Requests arrive on the req channel, one transaction each, and every request
// gives exactly one transaction on the res channel. The cfg channel writes the
// base seed and is always ready; write it only while no request is in flight.
// All arithmetic runs through one multiply-add unit that forms each 64-bit
// product from three partial products of a single 32x32 multiplier, stepped
// by a small sequencer. Work per request, in order:
//   load seed and unused codes: the result goes straight out.
//   next: one LCG step and one output multiply.
//   skip ahead: a multiply and an increment product per set bit of step_count,
//     an increment and a square product per lower bit, then one apply product.
//   stream seed: a stride product first, then skip ahead.
//   peek: skip ahead, then one LCG step and one output multiply.
// req.ready is high only while the sequencer is idle, so one request is in
// work at a time and a new request is taken only once the last is through. The
// finished word sits in an output register, so the next request is taken
// while it waits; if it is still unread when the next word is done, the
// sequencer holds and req.ready stays low. Reset sets the seed to zero and
// the base seed to one.

`default_nettype none

module pcg_rxs_m_xs_with_skip_ahead (
	input  logic clk,
	input  logic arst_n,
	pcg_cfg_if.sink   cfg,
	pcg_req_if.sink   req,
	pcg_res_if.source res
);
	import pcg_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;
	req_code_t  req_q;

	// Architectural state and configuration.
	word_t gen_q;
	word_t base_q;

	// Working registers of the sequencer.
	word_t n_q;
	word_t mul_q;
	word_t inc_q;
	word_t amul_q;
	word_t ainc_q;
	word_t s_q;
	word_t res_pend_q;

	// Output register.
	logic  out_valid_q;
	word_t out_q;

	logic    accept;
	logic    fin_go;
	logic    mul_en;
	logic    mul_done;
	mul_op_t mul_op;
	word_t   mul_p;
	rot_t    rot;
	word_t   perm_x;
	word_t   n_shift;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || res.ready);
	assign res.valid = out_valid_q;
	assign res.result_value = out_q;
	assign n_shift = n_q >> 1;

	// The output permutation's random shift: the top five bits plus five.
	assign rot = rot_t'(s_q[WordW-1 -: RotSelW]) + PERM_ROT_ADD;
	assign perm_x = (s_q >> rot) ^ s_q;

	pcg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (mul_en),
		.op     (mul_op),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the operands handed to the multiply-add unit.
	always_comb begin
		state_d = state_q;
		mul_en = 1'b0;
		mul_op.a = amul_q;
		mul_op.b = mul_q;
		mul_op.c = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (req.req_type)
						REQ_NEXT: state_d = ST_STEP;
						REQ_SKIP: state_d = ST_JTEST;
						REQ_STREAM: state_d = ST_STRIDE;
						REQ_PEEK: state_d = ST_JTEST;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_STRIDE: begin
				mul_en = 1'b1;
				mul_op.a = n_q;
				mul_op.b = LCG_STRIDE;
				if (mul_done) begin
					state_d = ST_JTEST;
				end
			end
			ST_JTEST: begin
				if (n_q == '0) begin
					state_d = ST_JAPPLY;
				end else if (n_q[0]) begin
					state_d = ST_JMUL;
				end else begin
					state_d = ST_JINC2;
				end
			end
			ST_JMUL: begin
				mul_en = 1'b1;
				mul_op.a = amul_q;
				mul_op.b = mul_q;
				if (mul_done) begin
					state_d = ST_JINC;
				end
			end
			ST_JINC: begin
				mul_en = 1'b1;
				mul_op.a = ainc_q;
				mul_op.b = mul_q;
				mul_op.c = inc_q;
				if (mul_done) begin
					// After the top set bit the remaining powers are not needed.
					state_d = (n_shift == '0) ? ST_JAPPLY : ST_JINC2;
				end
			end
			ST_JINC2: begin
				mul_en = 1'b1;
				mul_op.a = inc_q;
				mul_op.b = mul_q + word_t'(1);
				if (mul_done) begin
					state_d = ST_JSQR;
				end
			end
			ST_JSQR: begin
				mul_en = 1'b1;
				mul_op.a = mul_q;
				mul_op.b = mul_q;
				if (mul_done) begin
					state_d = ST_JTEST;
				end
			end
			ST_JAPPLY: begin
				mul_en = 1'b1;
				mul_op.a = amul_q;
				mul_op.b = s_q;
				mul_op.c = ainc_q;
				if (mul_done) begin
					state_d = (req_q == REQ_PEEK) ? ST_STEP : ST_FIN;
				end
			end
			ST_STEP: begin
				mul_en = 1'b1;
				mul_op.a = LCG_MULT;
				mul_op.b = s_q;
				mul_op.c = LCG_INC;
				if (mul_done) begin
					state_d = ST_PERM;
				end
			end
			ST_PERM: begin
				mul_en = 1'b1;
				mul_op.a = perm_x;
				mul_op.b = PERM_MULT;
				if (mul_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Generator seed, base seed and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			base_q <= word_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				base_q <= word_t'(cfg.base_seed);
			end
			if (accept && req.req_type == REQ_LOAD) begin
				gen_q <= req.seed_in;
			end else if (mul_done && state_q == ST_STEP && req_q == REQ_NEXT) begin
				gen_q <= mul_p;
			end else if (mul_done && state_q == ST_JAPPLY
					&& (req_q == REQ_SKIP || req_q == REQ_STREAM)) begin
				gen_q <= mul_p;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= res_pend_q;
		end
		if (accept) begin
			req_q <= req_code_t'(req.req_type);
			n_q <= req.step_count;
			mul_q <= LCG_MULT;
			inc_q <= LCG_INC;
			amul_q <= word_t'(1);
			ainc_q <= '0;
			priority case (req.req_type)
				REQ_LOAD: begin
					s_q <= req.seed_in;
					res_pend_q <= req.seed_in;
				end
				REQ_STREAM: begin
					s_q <= base_q + word_t'(req.stream_offset);
					res_pend_q <= gen_q;
				end
				REQ_PEEK: begin
					s_q <= req.seed_in;
					res_pend_q <= gen_q;
				end
				default: begin
					s_q <= gen_q;
					res_pend_q <= gen_q;
				end
			endcase
		end else if (mul_done) begin
			unique case (state_q)
				ST_STRIDE: n_q <= mul_p;
				ST_JMUL: amul_q <= mul_p;
				ST_JINC: ainc_q <= mul_p;
				ST_JINC2: inc_q <= mul_p;
				ST_JSQR: begin
					mul_q <= mul_p;
					n_q <= n_shift;
				end
				ST_JAPPLY: begin
					s_q <= mul_p;
					res_pend_q <= mul_p;
				end
				ST_STEP: s_q <= mul_p;
				ST_PERM: res_pend_q <= (mul_p >> PERM_XS_SHIFT) ^ mul_p;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/pcg_mul.sv
// Iterative 64-bit multiply-add modulo 2^64 built on one 32x32 multiplier.
`default_nettype none

module pcg_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  pcg_pkg::mul_op_t op,
	output logic            done,
	output pcg_pkg::word_t  p
);
	import pcg_pkg::*;

	mul_phase_t phase_q;
	word_t      acc_q;
	half_t      x;
	half_t      y;
	word_t      prod;
	word_t      sum;

	// Three partial products cover the low 64 bits; the high-by-high term drops out.
	always_comb begin
		x = op.a[HalfW-1:0];
		y = op.b[HalfW-1:0];
		unique case (phase_q)
			MUL_LL: begin
				x = op.a[HalfW-1:0];
				y = op.b[HalfW-1:0];
			end
			MUL_LH: begin
				x = op.a[HalfW-1:0];
				y = op.b[WordW-1:HalfW];
			end
			MUL_HL: begin
				x = op.a[WordW-1:HalfW];
				y = op.b[HalfW-1:0];
			end
			default: begin
				x = op.a[HalfW-1:0];
				y = op.b[HalfW-1:0];
			end
		endcase
		prod = word_t'(x) * word_t'(y);
		if (phase_q == MUL_LL) begin
			sum = op.c + prod;
		end else begin
			sum = acc_q + {prod[HalfW-1:0], half_t'(0)};
		end
	end

	assign done = en && (phase_q == MUL_HL);
	assign p = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MUL_LL;
		end else if (!en || phase_q == MUL_HL) begin
			phase_q <= MUL_LL;
		end else if (phase_q == MUL_LL) begin
			phase_q <= MUL_LH;
		end else begin
			phase_q <= MUL_HL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= sum;
		end
	end

endmodule

`default_nettype wire
